// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_STR  = 6'b000010,
        MODE_ESC  = 6'b000100,
        MODE_HEX2 = 6'b001000,
        MODE_HEX4 = 6'b010000,
        MODE_OCT  = 6'b100000
    } mode_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_DATA    = 3'd0;
    localparam status_t ST_CLOSED  = 3'd1;
    localparam status_t ST_NOT_STR = 3'd2;
    localparam status_t ST_BAD_HEX = 3'd3;
    localparam status_t ST_BAD_ESC = 3'd4;
    localparam status_t ST_UNTERM  = 3'd5;

    localparam logic [1:0] QK_DQUOTE = 2'd0;
    localparam logic [1:0] QK_SQUOTE = 2'd1;
    localparam logic [1:0] QK_BTICK  = 2'd2;

    localparam logic [7:0] CH_EOI    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BELL   = 8'h07;
    localparam logic [7:0] CH_ESCAPE = 8'h1b;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [2:0] HEX2_DIGITS = 3'd2;
    localparam logic [2:0] HEX4_DIGITS = 3'd4;
    localparam logic [2:0] OCT_DIGITS  = 3'd3;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  qk;
        logic [2:0]  dc;
        logic [15:0] cv;
    } state_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } res_t;

    typedef struct packed {
        state_t     state_next;
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } dec_out_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = 5'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = 5'(b - 8'h37);
        end
        return d;
    endfunction

endpackage

// ===== design/jsu_decoder.sv =====
module jsu_decoder (
    input  jsu_pkg::state_t   state,
    input  logic [7:0]        in_byte,
    output jsu_pkg::dec_out_t dec
);
    import jsu_pkg::*;

    typedef struct packed {
        mode_t mode;
        logic  has;
        res_t  res;
    } body_t;

    function automatic logic [7:0] quote_byte(input logic [1:0] qk);
        logic [7:0] q;
        q = CH_DQUOTE;
        if (qk == QK_SQUOTE) begin
            q = CH_SQUOTE;
        end else if (qk == QK_BTICK) begin
            q = CH_BTICK;
        end
        return q;
    endfunction

    function automatic body_t body_step(input logic [7:0] b, input logic [1:0] qk);
        body_t r;
        r.mode       = MODE_STR;
        r.has        = 1'b1;
        r.res.data   = b;
        r.res.status = ST_DATA;
        r.res.last   = 1'b0;
        if (b == CH_EOI) begin
            r.mode       = MODE_IDLE;
            r.res.data   = 8'h00;
            r.res.status = ST_UNTERM;
        end else if (b == CH_BSLASH) begin
            r.mode = MODE_ESC;
            r.has  = 1'b0;
        end else if (b == quote_byte(qk)) begin
            r.mode       = MODE_IDLE;
            r.res.data   = 8'h00;
            r.res.status = ST_CLOSED;
        end
        return r;
    endfunction

    body_t       body;
    logic [4:0]  hd;
    logic [2:0]  dc_inc;
    logic [15:0] cv_hex;
    logic [15:0] cv_oct;
    logic        is_oct;
    state_t      sn;
    logic [1:0]  n;
    res_t        r0;
    res_t        r1;

    always_comb begin
        body   = body_step(in_byte, state.qk);
        hd     = hex_digit(in_byte);
        dc_inc = state.dc + 3'd1;
        cv_hex = {state.cv[11:0], hd[3:0]};
        cv_oct = {state.cv[12:0], in_byte[2:0]};
        is_oct = (in_byte >= 8'h30) && (in_byte <= 8'h37);

        sn = state;
        n  = 2'd0;
        r0 = '0;
        r1 = '0;

        unique case (state.mode) inside
            MODE_STR: begin
                sn.mode = body.mode;
                r0      = body.res;
                n       = {1'b0, body.has};
            end
            MODE_ESC: begin
                sn.mode   = MODE_STR;
                n         = 2'd1;
                r0.status = ST_DATA;
                case (in_byte) inside
                    CH_EOI: begin
                        sn.mode   = MODE_IDLE;
                        r0.status = ST_UNTERM;
                    end
                    CH_DQUOTE, CH_SQUOTE, CH_BTICK, CH_BSLASH, CH_SLASH: r0.data = in_byte;
                    8'h62: r0.data = CH_BS;
                    8'h66: r0.data = CH_FF;
                    8'h6e: r0.data = CH_LF;
                    8'h72: r0.data = CH_CR;
                    8'h74: r0.data = CH_TAB;
                    8'h61: r0.data = CH_BELL;
                    8'h65: r0.data = CH_ESCAPE;
                    8'h78, 8'h75: begin
                        sn.mode = (in_byte == 8'h78) ? MODE_HEX2 : MODE_HEX4;
                        sn.dc   = 3'd0;
                        sn.cv   = 16'h0000;
                        n       = 2'd0;
                    end
                    [8'h30:8'h37]: begin
                        sn.mode = MODE_OCT;
                        sn.dc   = 3'd1;
                        sn.cv   = {13'd0, in_byte[2:0]};
                        n       = 2'd0;
                    end
                    default: begin
                        sn.mode   = MODE_IDLE;
                        r0.status = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX2, MODE_HEX4: begin
                if (hd[4]) begin
                    sn.mode   = MODE_IDLE;
                    r0.status = ST_BAD_HEX;
                    n         = 2'd1;
                end else begin
                    sn.cv = cv_hex;
                    sn.dc = dc_inc;
                    if (state.mode == MODE_HEX4) begin
                        if (dc_inc >= HEX4_DIGITS) begin
                            sn.mode = MODE_STR;
                            r0.data = cv_hex[15:8];
                            r1.data = cv_hex[7:0];
                            n       = 2'd2;
                        end
                    end else if (dc_inc >= HEX2_DIGITS) begin
                        sn.mode = MODE_STR;
                        r0.data = cv_hex[7:0];
                        n       = 2'd1;
                    end
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    sn.cv = cv_oct;
                    sn.dc = dc_inc;
                    if (dc_inc >= OCT_DIGITS) begin
                        sn.mode = MODE_STR;
                        r0.data = cv_oct[7:0];
                        n       = 2'd1;
                    end
                end else begin
                    r0.data = state.cv[7:0];
                    sn.mode = body.mode;
                    r1      = body.res;
                    n       = body.has ? 2'd2 : 2'd1;
                end
            end
            default: begin
                if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE || in_byte == CH_BTICK) begin
                    sn.mode = MODE_STR;
                    sn.qk   = (in_byte == CH_DQUOTE) ? QK_DQUOTE :
                              ((in_byte == CH_SQUOTE) ? QK_SQUOTE : QK_BTICK);
                end else begin
                    sn.mode   = MODE_IDLE;
                    r0.status = ST_NOT_STR;
                    n         = 2'd1;
                end
            end
        endcase

        r0.last = (n == 2'd1);
        r1.last = 1'b1;

        dec.state_next = sn;
        dec.n          = n;
        dec.r0         = r0;
        dec.r1         = r1;
    end

endmodule

// ===== design/jsu_out_pair.sv =====
module jsu_out_pair (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic [1:0]    load_n,
    input  jsu_pkg::res_t load_r0,
    input  jsu_pkg::res_t load_r1,
    output logic          can_load,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic [2:0]    m_tuser,
    output logic          m_tlast
);
    import jsu_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       slot0_reg;
    res_t       slot1_reg;
    logic       take;

    assign take     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = load_n;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= load_r0;
            slot1_reg <= load_r1;
        end else if (take) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg.data;
    assign m_tuser  = slot0_reg.status;
    assign m_tlast  = slot0_reg.last;

endmodule

// ===== design/json_string_unescaper.sv =====
// Channel | Port group          | Requests carry
// --------+---------------------+-----------------------------------------------
// input   | s_tvalid/tready     | tdata[7:0] in_byte (0 = end of input)
// result  | m_tvalid/tready     | tdata[7:0] out_byte, tuser[2:0] status,
//         |                     | tlast last_of_run
//
// One input byte per cycle while can_load is high; the byte and results are registered.
// A byte giving two results (\u, octal run end) stalls input while both slots are full.
// The two-slot result register drains one result per cycle while m_tready is high.
// aresetn is synchronous, active low; it returns the parser to idle.
// Either side may stall at any time without loss.
module json_string_unescaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [2:0] status
    output logic       m_tlast
);
    import jsu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    dec_out_t   dec;
    logic       can_load;
    logic       proc;

    assign proc     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode <= MODE_IDLE;
            state_reg.qk   <= QK_DQUOTE;
            state_reg.dc   <= 3'd0;
            state_reg.cv   <= 16'h0000;
        end else if (proc) begin
            state_reg <= dec.state_next;
        end
    end

    jsu_decoder u_dec (
        .state   (state_reg),
        .in_byte (in_byte_reg),
        .dec     (dec)
    );

    jsu_out_pair u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc),
        .load_n   (dec.n),
        .load_r0  (dec.r0),
        .load_r1  (dec.r1),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/jsu_checker.sv =====
module jsu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);
    import jsu_pkg::*;

    logic s_take;
    assign s_take = s_tvalid && s_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_status_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DATA) |-> (m_tdata == 8'h00) && m_tlast)
        else $error("status result carries data or is not last of run");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_DATA || m_tuser == ST_CLOSED || m_tuser == ST_NOT_STR
                      || m_tuser == ST_BAD_HEX || m_tuser == ST_BAD_ESC
                      || m_tuser == ST_UNTERM))
        else $error("status code out of range");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) && !s_take |=> !m_tvalid)
        else $error("result without an accepted byte after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);

// ===== test/tb_json_string_unescaper.sv =====
module tb_json_string_unescaper;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    typedef struct {
        logic [7:0] b;
        bit         hold;   // wait for all results before sending
    } byte_req_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    json_string_unescaper uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    byte_req_t   pending_bytes[$];
    res_t        expected_results[$];
    res_t        burst[$];
    logic        took     = 1'b0;
    int          n_sent   = 0;
    int          n_total  = 0;
    int          n_errors = 0;

    // decoder state
    mode_t       pm    = MODE_IDLE;
    logic [1:0]  qkind = QK_DQUOTE;
    logic [2:0]  ndig  = 3'd0;
    logic [15:0] acc   = 16'h0000;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic int hex_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] quote_of(input logic [1:0] k);
        case (k)
            QK_SQUOTE: return CH_SQUOTE;
            QK_BTICK:  return CH_BTICK;
            default:   return CH_DQUOTE;
        endcase
    endfunction

    task automatic emit(input logic [7:0] data, input status_t st);
        res_t r;
        r.data   = data;
        r.status = st;
        r.last   = 1'b0;
        burst.push_back(r);
    endtask

    task automatic body_byte(input logic [7:0] b);
        if (b == CH_EOI) begin
            pm = MODE_IDLE;
            emit(8'h00, ST_UNTERM);
        end else if (b == CH_BSLASH) begin
            pm = MODE_ESC;
        end else if (b == quote_of(qkind)) begin
            pm = MODE_IDLE;
            emit(8'h00, ST_CLOSED);
        end else begin
            emit(b, ST_DATA);
        end
    endtask

    task automatic escape_byte(input logic [7:0] b);
        pm = MODE_STR;
        case (b) inside
            CH_EOI: begin
                pm = MODE_IDLE;
                emit(8'h00, ST_UNTERM);
            end
            CH_DQUOTE, CH_SQUOTE, CH_BTICK, CH_BSLASH, CH_SLASH: emit(b, ST_DATA);
            "b": emit(CH_BS, ST_DATA);
            "f": emit(CH_FF, ST_DATA);
            "n": emit(CH_LF, ST_DATA);
            "r": emit(CH_CR, ST_DATA);
            "t": emit(CH_TAB, ST_DATA);
            "a": emit(CH_BELL, ST_DATA);
            "e": emit(CH_ESCAPE, ST_DATA);
            "x", "u": begin
                pm   = (b == "x") ? MODE_HEX2 : MODE_HEX4;
                ndig = 3'd0;
                acc  = 16'h0000;
            end
            default: begin
                if (b >= "0" && b <= "7") begin
                    pm   = MODE_OCT;
                    ndig = 3'd1;
                    acc  = {13'd0, b[2:0]};
                end else begin
                    pm = MODE_IDLE;
                    emit(8'h00, ST_BAD_ESC);
                end
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int   d;
        res_t r;
        burst.delete();
        case (pm) inside
            MODE_STR: body_byte(b);
            MODE_ESC: escape_byte(b);
            MODE_HEX2, MODE_HEX4: begin
                d = hex_val(b);
                if (d < 0) begin
                    pm = MODE_IDLE;
                    emit(8'h00, ST_BAD_HEX);
                end else begin
                    acc  = {acc[11:0], d[3:0]};
                    ndig = ndig + 3'd1;
                    if (ndig >= ((pm == MODE_HEX2) ? HEX2_DIGITS : HEX4_DIGITS)) begin
                        if (pm == MODE_HEX4) emit(acc[15:8], ST_DATA);
                        emit(acc[7:0], ST_DATA);
                        pm = MODE_STR;
                    end
                end
            end
            MODE_OCT: begin
                if (b >= "0" && b <= "7") begin
                    acc  = {acc[12:0], b[2:0]};
                    ndig = ndig + 3'd1;
                    if (ndig >= OCT_DIGITS) begin
                        pm = MODE_STR;
                        emit(acc[7:0], ST_DATA);
                    end
                end else begin
                    pm = MODE_STR;
                    emit(acc[7:0], ST_DATA);
                    body_byte(b);
                end
            end
            default: begin
                if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BTICK) begin
                    qkind = (b == CH_DQUOTE) ? QK_DQUOTE :
                            (b == CH_SQUOTE) ? QK_SQUOTE : QK_BTICK;
                    pm    = MODE_STR;
                end else begin
                    pm = MODE_IDLE;
                    emit(8'h00, ST_NOT_STR);
                end
            end
        endcase
        foreach (burst[i]) begin
            r      = burst[i];
            r.last = (i == burst.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // result check and request prediction
    always @(posedge aclk) begin : mon
        res_t want;
        if (!aresetn) begin
            pm    = MODE_IDLE;
            qkind = QK_DQUOTE;
            ndig  = 3'd0;
            acc   = 16'h0000;
            took <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result data %02h status %0d last %0d",
                                           m_tdata, m_tuser, m_tlast));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.data)
                        report_error($sformatf("data %02h, want %02h", m_tdata, want.data));
                    if (m_tuser !== want.status)
                        report_error($sformatf("status %0d, want %0d", m_tuser, want.status));
                    if (m_tlast !== want.last)
                        report_error($sformatf("last %0d, want %0d", m_tlast, want.last));
                end
            end
            took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) decode_byte(s_tdata);
        end
    end

    // request driver and result backpressure
    always @(negedge aclk) begin : drv
        logic       vld;
        logic [7:0] dat;
        int         send_idle;
        int         recv_idle;
        vld = s_tvalid;
        dat = s_tdata;
        if (n_sent * 3 < n_total) begin
            send_idle = 24;
            recv_idle = 73;
        end else if (n_sent * 3 < n_total * 2) begin
            send_idle = 73;
            recv_idle = 24;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (aresetn) begin
            if (took) begin
                void'(pending_bytes.pop_front());
                n_sent++;
                vld = 1'b0;
            end
            if (!vld && pending_bytes.size() > 0) begin
                if (!(pending_bytes[0].hold && expected_results.size() != 0) &&
                    $urandom_range(99) >= send_idle) begin
                    vld = 1'b1;
                    dat = pending_bytes[0].b;
                end
            end
        end
        s_tvalid <= vld;
        s_tdata  <= dat;
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic put(input logic [7:0] b, input bit hold = 1'b0);
        byte_req_t q;
        q.b    = b;
        q.hold = hold;
        pending_bytes.push_back(q);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_hex_digit();
        string digits;
        digits = "0123456789abcdefABCDEF";
        put(digits[$urandom_range(21)]);
    endtask

    task automatic put_literal();
        logic [7:0] q;
        logic [7:0] b;
        string      esc;
        int         n;
        esc = "\"'\\/bfnrtae";
        case ($urandom_range(2))
            0:       q = CH_DQUOTE;
            1:       q = CH_SQUOTE;
            default: q = CH_BTICK;
        endcase
        put(q, $urandom_range(49) == 0);
        n = $urandom_range(8);
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    do b = 8'($urandom_range(1, 255));
                    while (b == CH_BSLASH || b == q);
                    put(b);
                end
                3, 4: begin
                    put(CH_BSLASH);
                    if ($urandom_range(4) == 0) put(CH_BTICK);
                    else put(esc[$urandom_range(esc.len() - 1)]);
                end
                5: begin
                    put_str("\\x");
                    repeat (2) put_hex_digit();
                end
                6, 7: begin
                    put_str("\\u");
                    repeat (4) put_hex_digit();
                end
                default: begin
                    put(CH_BSLASH);
                    repeat ($urandom_range(1, 3)) put(8'("0" + $urandom_range(7)));
                end
            endcase
        end
        if ($urandom_range(99) < 85) put(q);
        else put(CH_EOI);
    endtask

    task automatic put_noise();
        case ($urandom_range(4))
            0: put(8'($urandom_range(255)));
            1: begin
                put(CH_DQUOTE);
                put(CH_BSLASH);
                put(8'($urandom_range(255)));
            end
            2: begin
                put(CH_SQUOTE);
                put_str($urandom_range(1) ? "\\x" : "\\u");
                put_hex_digit();
                put(8'($urandom_range(255)));
            end
            3: begin
                put(CH_BTICK);
                put(CH_BSLASH);
                repeat ($urandom_range(1, 2)) put(8'("0" + $urandom_range(7)));
                put(8'($urandom_range(255)));
            end
            default: begin
                put(CH_DQUOTE);
                put(CH_BSLASH);
                put(CH_EOI);
            end
        endcase
    endtask

    initial begin
        put(CH_DQUOTE);
        put(8'hff);
        put(8'h01);
        put_str("\\xFf\\uAb09\\777\\1\"");
        put(CH_SQUOTE, 1'b1);
        put_str("\\q");
        put_str("z");
        put(CH_BTICK);
        put(CH_EOI);
        while (pending_bytes.size() < 430) begin
            if ($urandom_range(99) < 80) put_literal();
            else put_noise();
        end
        n_total = pending_bytes.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
